// File: hdl/irc_message_tokenizer_unit_macros.svh
// ----------------------------------------------------------------------------
// IRC message tokenizer assertion macros
// Shared concurrent assertion forms for the tokenizer RTL.
// ----------------------------------------------------------------------------
`ifndef IRC_MESSAGE_TOKENIZER_UNIT_MACROS_SVH
`define IRC_MESSAGE_TOKENIZER_UNIT_MACROS_SVH

// Condition must hold at every clock edge outside reset
`define IRCTOK_ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond)) \
        else $error("tokenizer invariant violated");

// Antecedent implies consequent in the same cycle
`define IRCTOK_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("tokenizer implication violated");

`endif

// File: hdl/irctok_pkg.sv
// ----------------------------------------------------------------------------
// IRC tokenizer package
// Result record, field codes and sizing constants shared by the tokenizer.
// ----------------------------------------------------------------------------
package irctok_pkg;

    // Default bound on the number of parameters of one line
    localparam int MaxParamsDefault = 16;

    // Result queue depth (must allow two pushes next to one pending result)
    localparam int FifoDepth = 4;

    // Field codes
    localparam logic [2:0] FIELD_NICK  = 3'd0;
    localparam logic [2:0] FIELD_USER  = 3'd1;
    localparam logic [2:0] FIELD_HOST  = 3'd2;
    localparam logic [2:0] FIELD_VERB  = 3'd3;
    localparam logic [2:0] FIELD_MID   = 3'd4;
    localparam logic [2:0] FIELD_TRAIL = 3'd5;

    // Result kinds
    localparam logic KIND_BYTE  = 1'b0;
    localparam logic KIND_CLOSE = 1'b1;

    // Character codes
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_BANG  = 8'h21;
    localparam logic [7:0] CH_AT    = 8'h40;

    // One result item
    typedef struct packed {
        logic       kind;
        logic [2:0] field;
        logic [3:0] param_index;
        logic [7:0] data;
        logic       overflow;
        logic       line_end;
        logic       last;
    } t_result;

    // Whitespace test: space or tab
    function automatic logic is_ws(input logic [7:0] c);
        is_ws = (c == CH_SPACE) || (c == CH_TAB);
    endfunction

endpackage

// File: hdl/irctok_parse.sv
// ----------------------------------------------------------------------------
// IRC tokenizer parser
// Parse phase and parameter count registers with the per-character decode
// that yields up to two tagged results for each character or terminator.
// ----------------------------------------------------------------------------
module irctok_parse #(
    parameter int MAX_PARAMS = irctok_pkg::MaxParamsDefault
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_step,
    input  logic [7:0]           i_ch,
    input  logic                 i_term,
    output logic [1:0]           o_push_n,
    output irctok_pkg::t_result  o_res0,
    output irctok_pkg::t_result  o_res1
);

    localparam int CW  = $clog2(MAX_PARAMS + 1);
    localparam int CAP = (MAX_PARAMS - 1 < 15) ? MAX_PARAMS - 1 : 15;

    typedef enum logic [3:0] {
        PH_FRESH   = 4'd0,
        PH_LEAD    = 4'd1,
        PH_NICK    = 4'd2,
        PH_USER    = 4'd3,
        PH_HOST    = 4'd4,
        PH_PREVERB = 4'd5,
        PH_VERB    = 4'd6,
        PH_PSKIP   = 4'd7,
        PH_PARAM   = 4'd8,
        PH_TRAIL   = 4'd9
    } t_phase;

    t_phase              r_phase;
    t_phase              n_phase;
    logic [CW-1:0]       r_count;
    logic [CW-1:0]       n_count;
    logic [CW-1:0]       w_count_inc;
    logic [3:0]          w_idx;
    logic                w_ovf;
    logic [1:0]          w_nres;
    irctok_pkg::t_result w_r0;
    irctok_pkg::t_result w_r1;

    // Parameter tags derived from the count before this item
    assign w_idx       = (r_count < CW'(CAP)) ? 4'(r_count) : 4'(CAP);
    assign w_ovf       = (r_count >= CW'(MAX_PARAMS));
    assign w_count_inc = (r_count < CW'(MAX_PARAMS)) ? r_count + CW'(1) : r_count;

    // Build one result; parameter fields carry index and overflow
    function automatic irctok_pkg::t_result make_res(
        input logic       kind,
        input logic [2:0] field,
        input logic [7:0] data,
        input logic [3:0] idx,
        input logic       ovf
    );
        irctok_pkg::t_result r;
        logic                is_param;
        is_param      = (field == irctok_pkg::FIELD_MID) || (field == irctok_pkg::FIELD_TRAIL);
        r.kind        = kind;
        r.field       = field;
        r.param_index = is_param ? idx : 4'd0;
        r.data        = kind ? 8'd0 : data;
        r.overflow    = is_param ? ovf : 1'b0;
        r.line_end    = 1'b0;
        r.last        = 1'b0;
        return r;
    endfunction

    // Decode the current character against the parse phase
    always_comb begin
        n_phase = r_phase;
        n_count = r_count;
        w_nres  = 2'd0;
        w_r0    = make_res(irctok_pkg::KIND_CLOSE, irctok_pkg::FIELD_VERB, 8'd0, w_idx, w_ovf);
        w_r1    = w_r0;
        if (i_term) begin
            unique case (r_phase)
                PH_LEAD, PH_PREVERB, PH_VERB: begin
                    w_nres = 2'd1;
                end
                PH_NICK, PH_USER, PH_HOST: begin
                    w_nres = 2'd2;
                    w_r0   = make_res(irctok_pkg::KIND_CLOSE,
                                      (r_phase == PH_NICK) ? irctok_pkg::FIELD_NICK :
                                      (r_phase == PH_USER) ? irctok_pkg::FIELD_USER :
                                                             irctok_pkg::FIELD_HOST,
                                      8'd0, w_idx, w_ovf);
                end
                PH_PSKIP, PH_PARAM: begin
                    w_nres = 2'd1;
                    w_r0   = make_res(irctok_pkg::KIND_CLOSE, irctok_pkg::FIELD_MID,
                                      8'd0, w_idx, w_ovf);
                end
                PH_TRAIL: begin
                    w_nres = 2'd1;
                    w_r0   = make_res(irctok_pkg::KIND_CLOSE, irctok_pkg::FIELD_TRAIL,
                                      8'd0, w_idx, w_ovf);
                end
                default: begin
                    w_nres = 2'd0;
                end
            endcase
            n_phase = PH_FRESH;
            n_count = '0;
        end else begin
            unique case (r_phase)
                PH_FRESH, PH_LEAD: begin
                    if (irctok_pkg::is_ws(i_ch)) begin
                        n_phase = PH_LEAD;
                    end else if (i_ch == irctok_pkg::CH_COLON) begin
                        n_phase = PH_NICK;
                    end else begin
                        w_nres  = 2'd1;
                        w_r0    = make_res(irctok_pkg::KIND_BYTE, irctok_pkg::FIELD_VERB,
                                           i_ch, w_idx, w_ovf);
                        n_phase = PH_VERB;
                    end
                end
                PH_NICK: begin
                    w_nres = 2'd1;
                    if (i_ch == irctok_pkg::CH_BANG) begin
                        w_r0    = make_res(irctok_pkg::KIND_CLOSE, irctok_pkg::FIELD_NICK,
                                           8'd0, w_idx, w_ovf);
                        n_phase = PH_USER;
                    end else if (i_ch == irctok_pkg::CH_AT) begin
                        w_r0    = make_res(irctok_pkg::KIND_CLOSE, irctok_pkg::FIELD_NICK,
                                           8'd0, w_idx, w_ovf);
                        n_phase = PH_HOST;
                    end else if (irctok_pkg::is_ws(i_ch)) begin
                        w_r0    = make_res(irctok_pkg::KIND_CLOSE, irctok_pkg::FIELD_NICK,
                                           8'd0, w_idx, w_ovf);
                        n_phase = PH_PREVERB;
                    end else begin
                        w_r0 = make_res(irctok_pkg::KIND_BYTE, irctok_pkg::FIELD_NICK,
                                        i_ch, w_idx, w_ovf);
                    end
                end
                PH_USER: begin
                    w_nres = 2'd1;
                    if (i_ch == irctok_pkg::CH_AT) begin
                        w_r0    = make_res(irctok_pkg::KIND_CLOSE, irctok_pkg::FIELD_USER,
                                           8'd0, w_idx, w_ovf);
                        n_phase = PH_HOST;
                    end else if (irctok_pkg::is_ws(i_ch)) begin
                        w_r0    = make_res(irctok_pkg::KIND_CLOSE, irctok_pkg::FIELD_USER,
                                           8'd0, w_idx, w_ovf);
                        n_phase = PH_PREVERB;
                    end else begin
                        w_r0 = make_res(irctok_pkg::KIND_BYTE, irctok_pkg::FIELD_USER,
                                        i_ch, w_idx, w_ovf);
                    end
                end
                PH_HOST: begin
                    w_nres = 2'd1;
                    if (irctok_pkg::is_ws(i_ch)) begin
                        w_r0    = make_res(irctok_pkg::KIND_CLOSE, irctok_pkg::FIELD_HOST,
                                           8'd0, w_idx, w_ovf);
                        n_phase = PH_PREVERB;
                    end else begin
                        w_r0 = make_res(irctok_pkg::KIND_BYTE, irctok_pkg::FIELD_HOST,
                                        i_ch, w_idx, w_ovf);
                    end
                end
                PH_PREVERB: begin
                    if (!irctok_pkg::is_ws(i_ch)) begin
                        w_nres  = 2'd1;
                        w_r0    = make_res(irctok_pkg::KIND_BYTE, irctok_pkg::FIELD_VERB,
                                           i_ch, w_idx, w_ovf);
                        n_phase = PH_VERB;
                    end
                end
                PH_VERB: begin
                    w_nres = 2'd1;
                    if (irctok_pkg::is_ws(i_ch)) begin
                        n_phase = PH_PSKIP;
                    end else begin
                        w_r0 = make_res(irctok_pkg::KIND_BYTE, irctok_pkg::FIELD_VERB,
                                        i_ch, w_idx, w_ovf);
                    end
                end
                PH_PSKIP: begin
                    if (irctok_pkg::is_ws(i_ch)) begin
                        n_phase = PH_PSKIP;
                    end else if (i_ch == irctok_pkg::CH_COLON) begin
                        n_phase = PH_TRAIL;
                    end else begin
                        w_nres  = 2'd1;
                        w_r0    = make_res(irctok_pkg::KIND_BYTE, irctok_pkg::FIELD_MID,
                                           i_ch, w_idx, w_ovf);
                        n_phase = PH_PARAM;
                    end
                end
                PH_PARAM: begin
                    w_nres = 2'd1;
                    if (irctok_pkg::is_ws(i_ch)) begin
                        w_r0    = make_res(irctok_pkg::KIND_CLOSE, irctok_pkg::FIELD_MID,
                                           8'd0, w_idx, w_ovf);
                        n_count = w_count_inc;
                        n_phase = PH_PSKIP;
                    end else begin
                        w_r0 = make_res(irctok_pkg::KIND_BYTE, irctok_pkg::FIELD_MID,
                                        i_ch, w_idx, w_ovf);
                    end
                end
                PH_TRAIL: begin
                    w_nres = 2'd1;
                    w_r0   = make_res(irctok_pkg::KIND_BYTE, irctok_pkg::FIELD_TRAIL,
                                      i_ch, w_idx, w_ovf);
                end
                default: begin
                    n_phase = PH_FRESH;
                end
            endcase
        end

        // Tag the final result of this item
        if (w_nres == 2'd1) begin
            w_r0.last     = 1'b1;
            w_r0.line_end = i_term;
        end else if (w_nres == 2'd2) begin
            w_r1.last     = 1'b1;
            w_r1.line_end = i_term;
        end
    end

    // Hold parse state; advance on each processed item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_FRESH;
            r_count <= '0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_count <= n_count;
        end
    end

    assign o_push_n = i_step ? w_nres : 2'd0;
    assign o_res0   = w_r0;
    assign o_res1   = w_r1;

endmodule

// File: hdl/irctok_fifo.sv
// ----------------------------------------------------------------------------
// IRC tokenizer result queue
// Small register queue that takes zero, one or two results per cycle and
// presents one result per cycle to the output channel while it is popped.
// ----------------------------------------------------------------------------
module irctok_fifo (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  logic [1:0]                                  i_push_n,
    input  irctok_pkg::t_result                         i_res0,
    input  irctok_pkg::t_result                         i_res1,
    input  logic                                        i_pop,
    output logic                                        o_valid,
    output irctok_pkg::t_result                         o_head,
    output logic [$clog2(irctok_pkg::FifoDepth+1)-1:0]  o_level
);

    localparam int AW = $clog2(irctok_pkg::FifoDepth);
    localparam int LW = $clog2(irctok_pkg::FifoDepth + 1);

    irctok_pkg::t_result r_mem [irctok_pkg::FifoDepth];
    logic [AW-1:0]       r_wr_ptr;
    logic [AW-1:0]       r_rd_ptr;
    logic [LW-1:0]       r_level;
    logic                w_pop;

    assign w_pop = i_pop && (r_level != '0);

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_level  <= '0;
        end else begin
            r_level  <= r_level + LW'(i_push_n) - LW'(w_pop);
            r_wr_ptr <= r_wr_ptr + AW'(i_push_n);
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + AW'(1);
            end
        end
    end

    // Store pushed results in order
    always_ff @(posedge i_clk) begin
        if (i_push_n != 2'd0) begin
            r_mem[r_wr_ptr] <= i_res0;
        end
        if (i_push_n == 2'd2) begin
            r_mem[r_wr_ptr + AW'(1)] <= i_res1;
        end
    end

    assign o_valid = (r_level != '0);
    assign o_head  = r_mem[r_rd_ptr];
    assign o_level = r_level;

endmodule

// File: hdl/irc_message_tokenizer_unit.sv
// ----------------------------------------------------------------------------
// IRC message tokenizer
// Streams one command-line character per transfer and tags each content byte
// with its field (prefix parts, verb, parameters), closing fields as they end.
//
//   channel   dir  tdata                               tuser          tlast
//   s (in)    in   [7:0] ch                            -              terminator
//   m (out)   out  [3:0] param_index [11:4] data       [0] kind       last
//                  [12] overflow [13] line_end          [3:1] field
//
// One input transfer per cycle is sustained while the queue has room; results leave
// at one per cycle while the output is ready. A terminator inside a prefix yields
// two results. Each character passes through the input register, then the parse
// step writes the four-entry result queue. Input ready drops only when the queue
// lacks room for two results. Reset (synchronous, active low) returns the parser
// to the line-start phase with a zero parameter count and empties the queue.
// ----------------------------------------------------------------------------
`include "irc_message_tokenizer_unit_macros.svh"

module irc_message_tokenizer_unit #(
    parameter int MAX_PARAMS = irctok_pkg::MaxParamsDefault
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input character stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] ch
    input  logic        i_s_tlast,   // terminator
    // Result stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata,   // [3:0] param_index, [11:4] data, [12] overflow,
                                     // [13] line_end, [15:14] zero
    output logic [3:0]  o_m_tuser,   // [0] kind, [3:1] field
    output logic        o_m_tlast    // last
);

    localparam int LW = $clog2(irctok_pkg::FifoDepth + 1);

    logic                r_in_valid;
    logic [7:0]          r_in_ch;
    logic                r_in_term;
    logic                w_pop;
    logic                w_step;
    logic [1:0]          w_push_n;
    logic [LW-1:0]       w_level;
    irctok_pkg::t_result w_res0;
    irctok_pkg::t_result w_res1;
    irctok_pkg::t_result w_head;

    // Output transfer and room for two more results
    assign w_pop      = o_m_tvalid && i_m_tready;
    assign w_step     = r_in_valid &&
                        (w_level <= LW'(irctok_pkg::FifoDepth - 2) + LW'(w_pop));
    assign o_s_tready = !r_in_valid || w_step;

    // Input register: load on transfer, drain on parse step
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_tvalid && o_s_tready) begin
            r_in_ch   <= i_s_tdata;
            r_in_term <= i_s_tlast;
        end
    end

    irctok_parse #(
        .MAX_PARAMS (MAX_PARAMS)
    ) u_parse (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_step),
        .i_ch     (r_in_ch),
        .i_term   (r_in_term),
        .o_push_n (w_push_n),
        .o_res0   (w_res0),
        .o_res1   (w_res1)
    );

    irctok_fifo u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push_n (w_push_n),
        .i_res0   (w_res0),
        .i_res1   (w_res1),
        .i_pop    (w_pop),
        .o_valid  (o_m_tvalid),
        .o_head   (w_head),
        .o_level  (w_level)
    );

    // Pack the head result onto the output channel
    assign o_m_tdata = {2'b00, w_head.line_end, w_head.overflow, w_head.data,
                        w_head.param_index};
    assign o_m_tuser = {w_head.field, w_head.kind};
    assign o_m_tlast = w_head.last;

    // Queue never holds more than its depth
    `IRCTOK_ASSERT_ALWAYS(a_level_bound, i_clk, i_rst_n, w_level <= LW'(irctok_pkg::FifoDepth))
    // A field-closed result carries no content byte
    `IRCTOK_ASSERT_IMPLY(a_close_no_data, i_clk, i_rst_n, o_m_tvalid && o_m_tuser[0], o_m_tdata[11:4] == 8'd0)
    // Line end only on the final result of an item
    `IRCTOK_ASSERT_IMPLY(a_line_end_last, i_clk, i_rst_n, o_m_tvalid && o_m_tdata[13], o_m_tlast)
    // Two results are pushed only for a terminator
    `IRCTOK_ASSERT_IMPLY(a_pair_on_term, i_clk, i_rst_n, w_push_n == 2'd2, r_in_term && w_res1.line_end)

endmodule

// File: verif/irc_message_tokenizer_checker.sv
// ----------------------------------------------------------------------------
// IRC message tokenizer checker
// Watches the character and result streams of the tokenizer, tracks the parse
// state of each line, predicts the tagged bytes and field closes that every
// accepted character causes, and compares each result transfer field by field
// with the oldest prediction. Reports how many mismatches it found and how
// many predicted results are still outstanding.
// ----------------------------------------------------------------------------
module irc_message_tokenizer_checker #(
    parameter int MAX_PARAMS = irctok_pkg::MaxParamsDefault
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Character stream, observed
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] ch
    input  logic        i_s_tlast,   // terminator
    // Result stream, observed
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [15:0] i_m_tdata,   // [3:0] param_index, [11:4] data, [12] overflow,
                                     // [13] line_end, [15:14] zero
    input  logic [3:0]  i_m_tuser,   // [0] kind, [3:1] field
    input  logic        i_m_tlast,   // last
    // Status
    output int          o_fail_count,
    output int          o_pending
);

    // Where the parser stands within the current line
    typedef enum logic [3:0] {
        LINE_START,
        LEAD_BLANK,
        IN_NICK,
        IN_USER,
        IN_HOST,
        BEFORE_VERB,
        IN_VERB,
        PARAM_GAP,
        IN_PARAM,
        IN_TRAIL
    } t_line_state;

    t_line_state         line_state;
    logic [6:0]          params_closed;
    irctok_pkg::t_result expected_tokens[$];
    int                  fail_total = 0;

    assign o_fail_count = fail_total;

    function automatic logic is_blank(input logic [7:0] c);
        return (c == irctok_pkg::CH_SPACE) || (c == irctok_pkg::CH_TAB);
    endfunction

    // Build one result; parameter fields carry the saturated index and overflow
    function automatic irctok_pkg::t_result make_token(input logic kind,
                                                       input logic [2:0] fld,
                                                       input logic [7:0] c);
        irctok_pkg::t_result r;
        int                  cap;
        int                  pos;
        r = '0;
        cap = (MAX_PARAMS - 1 > 15) ? 15 : MAX_PARAMS - 1;
        pos = int'(params_closed);
        r.kind = kind;
        r.field = fld;
        r.data = (kind == irctok_pkg::KIND_CLOSE) ? 8'h00 : c;
        if (fld == irctok_pkg::FIELD_MID || fld == irctok_pkg::FIELD_TRAIL) begin
            r.param_index = 4'((pos < cap) ? pos : cap);
            r.overflow = (pos >= MAX_PARAMS);
        end
        return r;
    endfunction

    function automatic void bump_params();
        if (int'(params_closed) < MAX_PARAMS) begin
            params_closed++;
        end
    endfunction

    // Advance the line state by one character or terminator, queue its results
    function automatic void tokenize(input logic [7:0] c, input logic term);
        irctok_pkg::t_result step_out[$];
        irctok_pkg::t_result r;
        if (term) begin
            case (line_state)
                LEAD_BLANK, BEFORE_VERB, IN_VERB: begin
                    step_out = {step_out, make_token(irctok_pkg::KIND_CLOSE,
                                                     irctok_pkg::FIELD_VERB, 8'h00)};
                end
                IN_NICK: begin
                    step_out = {step_out, make_token(irctok_pkg::KIND_CLOSE,
                                                     irctok_pkg::FIELD_NICK, 8'h00)};
                    step_out = {step_out, make_token(irctok_pkg::KIND_CLOSE,
                                                     irctok_pkg::FIELD_VERB, 8'h00)};
                end
                IN_USER: begin
                    step_out = {step_out, make_token(irctok_pkg::KIND_CLOSE,
                                                     irctok_pkg::FIELD_USER, 8'h00)};
                    step_out = {step_out, make_token(irctok_pkg::KIND_CLOSE,
                                                     irctok_pkg::FIELD_VERB, 8'h00)};
                end
                IN_HOST: begin
                    step_out = {step_out, make_token(irctok_pkg::KIND_CLOSE,
                                                     irctok_pkg::FIELD_HOST, 8'h00)};
                    step_out = {step_out, make_token(irctok_pkg::KIND_CLOSE,
                                                     irctok_pkg::FIELD_VERB, 8'h00)};
                end
                PARAM_GAP, IN_PARAM: begin
                    step_out = {step_out, make_token(irctok_pkg::KIND_CLOSE,
                                                     irctok_pkg::FIELD_MID, 8'h00)};
                    bump_params();
                end
                IN_TRAIL: begin
                    step_out = {step_out, make_token(irctok_pkg::KIND_CLOSE,
                                                     irctok_pkg::FIELD_TRAIL, 8'h00)};
                    bump_params();
                end
                default: ;
            endcase
            if (step_out.size() > 0) begin
                r = step_out.pop_back();
                r.line_end = 1'b1;
                step_out = {step_out, r};
            end
            line_state = LINE_START;
            params_closed = '0;
        end else begin
            case (line_state)
                LINE_START, LEAD_BLANK: begin
                    if (is_blank(c)) begin
                        line_state = LEAD_BLANK;
                    end else if (c == irctok_pkg::CH_COLON) begin
                        line_state = IN_NICK;
                    end else begin
                        step_out = {step_out, make_token(irctok_pkg::KIND_BYTE,
                                                         irctok_pkg::FIELD_VERB, c)};
                        line_state = IN_VERB;
                    end
                end
                IN_NICK: begin
                    if (c == irctok_pkg::CH_BANG || c == irctok_pkg::CH_AT || is_blank(c)) begin
                        step_out = {step_out, make_token(irctok_pkg::KIND_CLOSE,
                                                         irctok_pkg::FIELD_NICK, 8'h00)};
                        line_state = (c == irctok_pkg::CH_BANG) ? IN_USER :
                                     (c == irctok_pkg::CH_AT) ? IN_HOST : BEFORE_VERB;
                    end else begin
                        step_out = {step_out, make_token(irctok_pkg::KIND_BYTE,
                                                         irctok_pkg::FIELD_NICK, c)};
                    end
                end
                IN_USER: begin
                    if (c == irctok_pkg::CH_AT || is_blank(c)) begin
                        step_out = {step_out, make_token(irctok_pkg::KIND_CLOSE,
                                                         irctok_pkg::FIELD_USER, 8'h00)};
                        line_state = (c == irctok_pkg::CH_AT) ? IN_HOST : BEFORE_VERB;
                    end else begin
                        step_out = {step_out, make_token(irctok_pkg::KIND_BYTE,
                                                         irctok_pkg::FIELD_USER, c)};
                    end
                end
                IN_HOST: begin
                    if (is_blank(c)) begin
                        step_out = {step_out, make_token(irctok_pkg::KIND_CLOSE,
                                                         irctok_pkg::FIELD_HOST, 8'h00)};
                        line_state = BEFORE_VERB;
                    end else begin
                        step_out = {step_out, make_token(irctok_pkg::KIND_BYTE,
                                                         irctok_pkg::FIELD_HOST, c)};
                    end
                end
                BEFORE_VERB: begin
                    if (!is_blank(c)) begin
                        step_out = {step_out, make_token(irctok_pkg::KIND_BYTE,
                                                         irctok_pkg::FIELD_VERB, c)};
                        line_state = IN_VERB;
                    end
                end
                IN_VERB: begin
                    if (is_blank(c)) begin
                        step_out = {step_out, make_token(irctok_pkg::KIND_CLOSE,
                                                         irctok_pkg::FIELD_VERB, 8'h00)};
                        line_state = PARAM_GAP;
                    end else begin
                        step_out = {step_out, make_token(irctok_pkg::KIND_BYTE,
                                                         irctok_pkg::FIELD_VERB, c)};
                    end
                end
                PARAM_GAP: begin
                    // A colon opens the trailing parameter only at a parameter start
                    if (c == irctok_pkg::CH_COLON) begin
                        line_state = IN_TRAIL;
                    end else if (!is_blank(c)) begin
                        step_out = {step_out, make_token(irctok_pkg::KIND_BYTE,
                                                         irctok_pkg::FIELD_MID, c)};
                        line_state = IN_PARAM;
                    end
                end
                IN_PARAM: begin
                    if (is_blank(c)) begin
                        step_out = {step_out, make_token(irctok_pkg::KIND_CLOSE,
                                                         irctok_pkg::FIELD_MID, 8'h00)};
                        bump_params();
                        line_state = PARAM_GAP;
                    end else begin
                        step_out = {step_out, make_token(irctok_pkg::KIND_BYTE,
                                                         irctok_pkg::FIELD_MID, c)};
                    end
                end
                IN_TRAIL: begin
                    step_out = {step_out, make_token(irctok_pkg::KIND_BYTE,
                                                     irctok_pkg::FIELD_TRAIL, c)};
                end
                default: begin
                    line_state = LINE_START;
                end
            endcase
        end
        if (step_out.size() > 0) begin
            r = step_out.pop_back();
            r.last = 1'b1;
            step_out = {step_out, r};
        end
        expected_tokens = {expected_tokens, step_out};
    endfunction

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned seen);
        if (want != seen) begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, seen);
            fail_total++;
        end
    endfunction

    // Predict on each character transfer, compare on each result transfer
    always @(posedge i_clk) begin : monitor
        irctok_pkg::t_result seen;
        irctok_pkg::t_result want;
        if (!i_rst_n) begin
            line_state = LINE_START;
            params_closed = '0;
            expected_tokens.delete();
        end else begin
            if (i_s_tvalid && i_s_tready) begin
                tokenize(i_s_tdata, i_s_tlast);
            end
            if (i_m_tvalid && i_m_tready) begin
                seen = '0;
                seen.kind = i_m_tuser[0];
                seen.field = i_m_tuser[3:1];
                seen.param_index = i_m_tdata[3:0];
                seen.data = i_m_tdata[11:4];
                seen.overflow = i_m_tdata[12];
                seen.line_end = i_m_tdata[13];
                seen.last = i_m_tlast;
                if (expected_tokens.size() == 0) begin
                    $display({"%0t: unexpected result: expected none, ",
                              "actual tuser %h tdata %h tlast %b"},
                             $time, i_m_tuser, i_m_tdata, i_m_tlast);
                    fail_total++;
                end else begin
                    want = expected_tokens.pop_front();
                    check_field("kind", want.kind, seen.kind);
                    check_field("field", want.field, seen.field);
                    check_field("param_index", want.param_index, seen.param_index);
                    check_field("data", want.data, seen.data);
                    check_field("overflow", want.overflow, seen.overflow);
                    check_field("line_end", want.line_end, seen.line_end);
                    check_field("last", want.last, seen.last);
                end
            end
        end
        o_pending <= expected_tokens.size();
    end

endmodule

// File: verif/irc_message_tokenizer_unit_test.sv
// ----------------------------------------------------------------------------
// IRC message tokenizer testbench
// Feeds the tokenizer command lines character by character: a short directed
// set of corner lines, then mostly well-formed random lines (prefix, verb,
// middle and trailing parameters, long parameter lists) mixed with noise
// lines. Both stream sides idle at random. A checker beside the block
// predicts and compares every result; this module gives the verdict.
// ----------------------------------------------------------------------------
module irc_message_tokenizer_unit_test;

    localparam int   CLK_PERIOD   = 20;
    localparam int   RESET_CYCLES = 5;
    localparam int   ITEM_TARGET  = 1400;
    localparam int   CYCLE_LIMIT  = 200000;
    localparam int   DRAIN_CYCLES = 10;
    localparam logic MID_LINE     = 1'b0;
    localparam logic END_OF_LINE  = 1'b1;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [7:0]  i_s_tdata;
    logic        i_s_tlast;
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [15:0] o_m_tdata;
    logic [3:0]  o_m_tuser;
    logic        o_m_tlast;

    int          fail_count;
    int          pending;
    int          chars_sent = 0;
    int unsigned cycle_count = 0;
    bit          steady_flow = 1'b0;

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    irc_message_tokenizer_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    irc_message_tokenizer_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (i_s_tvalid),
        .i_s_tready   (o_s_tready),
        .i_s_tdata    (i_s_tdata),
        .i_s_tlast    (i_s_tlast),
        .i_m_tvalid   (o_m_tvalid),
        .i_m_tready   (i_m_tready),
        .i_m_tdata    (o_m_tdata),
        .i_m_tuser    (o_m_tuser),
        .i_m_tlast    (o_m_tlast),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Abort a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Drive one character transfer; returns at the edge that accepts it
    task automatic send_item(input logic [7:0] c, input logic term);
        int gap;
        gap = steady_flow ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata <= c;
        i_s_tlast <= term;
        do @(posedge i_clk); while (!o_s_tready);
        chars_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            send_item(s[i], MID_LINE);
        end
    endtask

    // Terminator carries a random, ignored character
    task automatic end_line();
        send_item(8'($urandom_range(0, 255)), END_OF_LINE);
    endtask

    // Hold the sender until every predicted result has left the block
    task automatic wait_drained();
        i_s_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    function automatic logic [7:0] blank_byte();
        return $urandom_range(0, 1) ? irctok_pkg::CH_SPACE : irctok_pkg::CH_TAB;
    endfunction

    // Any byte, biased toward the characters the parser reacts to
    function automatic logic [7:0] noise_byte();
        case ($urandom_range(0, 7))
            0: return irctok_pkg::CH_SPACE;
            1: return irctok_pkg::CH_TAB;
            2: return irctok_pkg::CH_COLON;
            3: return irctok_pkg::CH_BANG;
            4: return irctok_pkg::CH_AT;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Non-blank token byte; markers (colon, bang, at) only when allowed
    function automatic logic [7:0] token_byte(input logic marks);
        logic [7:0] c;
        if (marks && $urandom_range(0, 7) == 0) begin
            case ($urandom_range(0, 2))
                0: return irctok_pkg::CH_COLON;
                1: return irctok_pkg::CH_BANG;
                default: return irctok_pkg::CH_AT;
            endcase
        end
        do begin
            c = 8'($urandom_range(0, 255));
        end while (c == irctok_pkg::CH_SPACE || c == irctok_pkg::CH_TAB ||
                   c == irctok_pkg::CH_COLON || c == irctok_pkg::CH_BANG ||
                   c == irctok_pkg::CH_AT);
        return c;
    endfunction

    task automatic send_token(input logic marks);
        send_item(token_byte(1'b0), MID_LINE);
        repeat ($urandom_range(0, 5)) send_item(token_byte(marks), MID_LINE);
    endtask

    task automatic send_gap();
        repeat ($urandom_range(1, 2)) send_item(blank_byte(), MID_LINE);
    endtask

    // One random line: mostly well formed, sometimes noise
    task automatic send_line();
        int n_params;
        steady_flow = ($urandom_range(0, 5) == 0);
        if ($urandom_range(0, 6) == 0) begin
            repeat ($urandom_range(0, 12)) send_item(noise_byte(), MID_LINE);
        end else begin
            repeat ($urandom_range(0, 2)) send_item(blank_byte(), MID_LINE);
            if ($urandom_range(0, 1)) begin
                send_item(irctok_pkg::CH_COLON, MID_LINE);
                send_token(1'b0);
                if ($urandom_range(0, 1)) begin
                    send_item(irctok_pkg::CH_BANG, MID_LINE);
                    send_token(1'b0);
                end
                if ($urandom_range(0, 1)) begin
                    send_item(irctok_pkg::CH_AT, MID_LINE);
                    send_token(1'b1);
                end
                send_gap();
            end
            send_token(1'b1);
            // Long lists push the parameter count past its bound
            n_params = ($urandom_range(0, 9) == 0) ? $urandom_range(14, 20)
                                                    : $urandom_range(0, 4);
            repeat (n_params) begin
                send_gap();
                send_token(1'b1);
            end
            if ($urandom_range(0, 2) == 0) begin
                send_gap();
                send_item(irctok_pkg::CH_COLON, MID_LINE);
                repeat ($urandom_range(0, 6)) send_item(noise_byte(), MID_LINE);
            end else if ($urandom_range(0, 3) == 0) begin
                send_gap();
            end
        end
        end_line();
    endtask

    // Result side: random stall before each transfer
    initial begin : result_sink
        int stall;
        i_m_tready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            stall = steady_flow ? 0 : $urandom_range(0, 5);
            if (stall > 0) begin
                i_m_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_m_tready <= 1'b1;
            do @(posedge i_clk); while (!o_m_tvalid);
        end
    end

    initial begin
        i_rst_n <= 1'b0;
        i_s_tvalid <= 1'b0;
        i_s_tdata <= '0;
        i_s_tlast <= MID_LINE;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Empty line: no result
        end_line();
        // Blank-only line closes an empty verb
        send_text(" \t");
        end_line();
        // Unterminated full prefix: host close, then empty verb
        send_text(":a!b@c");
        end_line();
        // Colon inside the verb, zero byte as parameter, trailing with top byte
        send_text("V: ");
        send_item(8'h00, MID_LINE);
        send_text(" :");
        send_item(8'hFF, MID_LINE);
        end_line();
        // Blank before the terminator closes an empty middle parameter
        send_text("x ");
        end_line();
        // Bare prefix opener: nick close, then empty verb
        send_text(":");
        end_line();

        wait_drained();

        while (chars_sent < ITEM_TARGET) begin
            send_line();
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
